// ----- design/rtss_pkg.sv -----
// Shared constants and types for the resistive touch sample sequencer.
package rtss_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COORD_BITS      = 12;
    localparam int THRESH_BITS     = 12;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(12);

    // Sequence phase, one-hot: pressure triple, X triple, Y triple.
    typedef enum logic [8:0] {
        PH_P0 = 9'b000000001,
        PH_P1 = 9'b000000010,
        PH_P2 = 9'b000000100,
        PH_X0 = 9'b000001000,
        PH_X1 = 9'b000010000,
        PH_X2 = 9'b000100000,
        PH_Y0 = 9'b001000000,
        PH_Y1 = 9'b010000000,
        PH_Y2 = 9'b100000000
    } t_phase;

endpackage

// ----- design/rtss_if.sv -----
// Valid/ready channel interfaces: sample requests in, touch result requests out.
interface rtss_sample_if #(
    parameter int SAMPLE_BITS = rtss_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rtss_result_if;
    logic                            valid;
    logic                            ready;
    logic                            touched;
    logic [rtss_pkg::COORD_BITS-1:0] x_position;
    logic [rtss_pkg::COORD_BITS-1:0] y_position;
    logic [rtss_pkg::COORD_BITS-1:0] pressure;

    modport source (output valid, output touched, output x_position, output y_position,
                    output pressure, input ready);
    modport sink   (input valid, input touched, input x_position, input y_position,
                    input pressure, output ready);
endinterface

// ----- design/resistive_touch_sample_sequencer_top.sv -----
// Top level of the resistive touch sample sequencer.
//
//  channel      | dir | payload                                    | bits
//  -------------+-----+--------------------------------------------+---------------
//  i_sample_if  | in  | sample                                     | SAMPLE_BITS
//  o_result_if  | out | touched, x_position, y_position, pressure  | 1,12,12,12
//  i_cfg_*      | in  | press_threshold (write only)               | 12
//
// One sample request is taken per cycle. A result request shows up on the
// output register in the cycle after the sample that completes the pressure
// triple (no touch) or the Y triple (touch). The input stalls only while a
// result waits untaken and the next sample would complete one of those two
// triples; every other sample is taken even under output back-pressure.
// Reset (synchronous, active low) returns to the first pressure sample and
// sets the threshold to 12.
module resistive_touch_sample_sequencer_top #(
    parameter int SAMPLE_BITS = rtss_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rtss_sample_if.sink                    i_sample_if,
    rtss_result_if.source                  o_result_if,
    input  logic                           i_cfg_we,
    input  logic [rtss_pkg::THRESH_BITS-1:0] i_cfg_wdata
);

    localparam int CMP_BITS = (SAMPLE_BITS > rtss_pkg::THRESH_BITS) ?
                              SAMPLE_BITS : rtss_pkg::THRESH_BITS;
    localparam int CB = rtss_pkg::COORD_BITS;

    // Median of three: clamp the larger of the first two by the third,
    // then take the larger of that and the smaller of the first two.
    function automatic logic [SAMPLE_BITS-1:0] mid3(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b,
        input logic [SAMPLE_BITS-1:0] c
    );
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (hi > c) begin
            hi = c;
        end
        return (lo > hi) ? lo : hi;
    endfunction

    // Sequence state.
    rtss_pkg::t_phase                r_phase,  n_phase;
    logic [SAMPLE_BITS-1:0]          r_first,  n_first;
    logic [SAMPLE_BITS-1:0]          r_second, n_second;
    logic [SAMPLE_BITS-1:0]          r_press,  n_press;
    logic [SAMPLE_BITS-1:0]          r_x,      n_x;
    logic [rtss_pkg::THRESH_BITS-1:0] r_thresh;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic          r_touched,   n_touched;
    logic [CB-1:0] r_x_pos,     n_x_pos;
    logic [CB-1:0] r_y_pos,     n_y_pos;
    logic [CB-1:0] r_p_out,     n_p_out;

    logic                   in_ready;
    logic                   in_accept;
    logic                   result_phase;
    logic [SAMPLE_BITS-1:0] med;
    logic                   below;

    // Only the last sample of the pressure or Y triple can produce a result.
    assign result_phase = (r_phase == rtss_pkg::PH_P2) || (r_phase == rtss_pkg::PH_Y2);
    assign in_ready     = !r_out_valid || o_result_if.ready || !result_phase;
    assign in_accept    = i_sample_if.valid && in_ready;

    assign med   = mid3(r_first, r_second, i_sample_if.sample);
    assign below = CMP_BITS'(med) < CMP_BITS'(r_thresh);

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_second    = r_second;
        n_press     = r_press;
        n_x         = r_x;
        n_out_valid = r_out_valid && !o_result_if.ready;
        n_touched   = r_touched;
        n_x_pos     = r_x_pos;
        n_y_pos     = r_y_pos;
        n_p_out     = r_p_out;
        if (in_accept) begin
            unique case (r_phase)
                rtss_pkg::PH_P1: begin
                    n_second = i_sample_if.sample;
                    n_phase  = rtss_pkg::PH_P2;
                end
                rtss_pkg::PH_P2: begin
                    n_press = med;
                    if (below) begin
                        n_out_valid = 1'b1;
                        n_touched   = 1'b0;
                        n_x_pos     = '0;
                        n_y_pos     = '0;
                        n_p_out     = CB'(med);
                        n_phase     = rtss_pkg::PH_P0;
                    end else begin
                        n_phase = rtss_pkg::PH_X0;
                    end
                end
                rtss_pkg::PH_X0: begin
                    n_first = i_sample_if.sample;
                    n_phase = rtss_pkg::PH_X1;
                end
                rtss_pkg::PH_X1: begin
                    n_second = i_sample_if.sample;
                    n_phase  = rtss_pkg::PH_X2;
                end
                rtss_pkg::PH_X2: begin
                    n_x     = med;
                    n_phase = rtss_pkg::PH_Y0;
                end
                rtss_pkg::PH_Y0: begin
                    n_first = i_sample_if.sample;
                    n_phase = rtss_pkg::PH_Y1;
                end
                rtss_pkg::PH_Y1: begin
                    n_second = i_sample_if.sample;
                    n_phase  = rtss_pkg::PH_Y2;
                end
                rtss_pkg::PH_Y2: begin
                    n_out_valid = 1'b1;
                    n_touched   = 1'b1;
                    n_x_pos     = CB'(r_x);
                    n_y_pos     = CB'(med);
                    n_p_out     = CB'(r_press);
                    n_phase     = rtss_pkg::PH_P0;
                end
                default: begin
                    // first pressure sample; a corrupt phase restarts here too
                    n_first = i_sample_if.sample;
                    n_phase = rtss_pkg::PH_P1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= rtss_pkg::PH_P0;
            r_first     <= '0;
            r_second    <= '0;
            r_press     <= '0;
            r_x         <= '0;
            r_thresh    <= rtss_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_second    <= n_second;
            r_press     <= n_press;
            r_x         <= n_x;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_touched <= n_touched;
        r_x_pos   <= n_x_pos;
        r_y_pos   <= n_y_pos;
        r_p_out   <= n_p_out;
    end

    assign i_sample_if.ready      = in_ready;
    assign o_result_if.valid      = r_out_valid;
    assign o_result_if.touched    = r_touched;
    assign o_result_if.x_position = r_x_pos;
    assign o_result_if.y_position = r_y_pos;
    assign o_result_if.pressure   = r_p_out;

endmodule

// ----- design/rtss_checker.sv -----
// Port-level checker for the touch sample sequencer, bound to the top level.
module rtss_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_out_touched,
    input logic [rtss_pkg::COORD_BITS-1:0] i_out_x,
    input logic [rtss_pkg::COORD_BITS-1:0] i_out_y,
    input logic [rtss_pkg::COORD_BITS-1:0] i_out_p
);

    // A held result request keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_touched) && $stable(i_out_x) &&
            $stable(i_out_y) && $stable(i_out_p))
        else $error("result request changed while stalled");

    // No-touch results carry zero coordinates.
    a_no_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_touched |-> i_out_x == '0 && i_out_y == '0)
        else $error("no-touch result with nonzero coordinates");

    // A new result only follows an accepted sample.
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !$past(i_out_valid && !i_out_ready) |->
            $past(i_in_valid && i_in_ready))
        else $error("result without a completing sample");

    // Input stalls only behind a pending result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with no pending result");

endmodule

bind resistive_touch_sample_sequencer_top rtss_checker u_rtss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample_if.valid),
    .i_in_ready    (i_sample_if.ready),
    .i_out_valid   (o_result_if.valid),
    .i_out_ready   (o_result_if.ready),
    .i_out_touched (o_result_if.touched),
    .i_out_x       (o_result_if.x_position),
    .i_out_y       (o_result_if.y_position),
    .i_out_p       (o_result_if.pressure)
);
